### src/gsk_pkg.sv
// shared types, constants and helper functions of the kernel matrix unit
`timescale 1ns / 1ps
package gsk_pkg;

   localparam int DIM    = 7;   // components per point
   localparam int COMP_W = 24;  // signed Q8.16 component
   localparam int WGT_W  = 24;  // unsigned Q8.16 weight
   localparam int XW     = 29;  // doubled query component
   localparam int DW     = 30;  // doubled difference
   localparam int MW     = 29;  // difference magnitude
   localparam int SQW    = 58;  // squared magnitude
   localparam int TW     = 20;  // saturated weighted term
   localparam int EW     = 21;  // saturated exponent sum
   localparam int IDXW   = 6;   // point index on the result channel
   localparam int KW     = 17;  // Q1.16 kernel value

   localparam logic [EW-1:0]    FLUSH_Q16  = EW'(12 << 16);
   localparam logic [15:0]      LN2_Q16    = 16'd45426;
   localparam logic [16:0]      LN2_RECIP  = 17'd94549;  // ceil(2^32 / ln2_q16)
   localparam logic [KW-1:0]    ONE_Q16    = 17'd65536;
   localparam logic [WGT_W-1:0] WEIGHT_RST = 24'd65536;

   // request kinds
   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // register indexes
   localparam logic [2:0] REG_SHIFT = 3'd7;

   typedef struct packed {
      logic            valid;
      logic [IDXW-1:0] idx;
      logic            last;
   } meta_type;

   // item travelling along the cell row
   typedef struct packed {
      meta_type                      meta;
      logic [DIM-1:0][COMP_W-1:0]    row;
      logic [EW-1:0]                 e1;
      logic [EW-1:0]                 e2;
   } tok_type;

   // floor(x / k) for the small constant divisors of the exp series
   function automatic logic [16:0] quot_by(input logic [16:0] x, input int k);
      logic [37:0] m;
      begin
         m = '0;
         case (k)
            1: quot_by = x;
            2: quot_by = x >> 1;
            3: begin
               m = 38'(x) * 38'(349526);
               quot_by = 17'(m >> 20);
            end
            4: quot_by = x >> 2;
            5: begin
               m = 38'(x) * 38'(209716);
               quot_by = 17'(m >> 20);
            end
            default: quot_by = x;
         endcase
      end
   endfunction

endpackage

### src/gaussian_split_kernel_matrix_unit.sv
// top level: point store, query scan, cell row, exp unit and result register
`timescale 1ns / 1ps
// Squared-exponential kernel row unit. Software clears the store and loads
// reference points (seven signed Q8.16 components each) one item per cycle;
// a query item is turned into a sum vector and a difference vector and the
// unit returns, for every stored point in load order, one transfer holding
// the point index and exp(-weighted squared distance) for both vectors in
// Q1.16, with tlast on the final point. A query on N stored points streams
// its N results at one per cycle while the result channel does not stall,
// after passing one store read, seven cells of four stages, a thirteen-stage
// exp unit and the result register; the store is read one row per cycle
// unless stalled, and the request side reopens only once the pipeline has
// drained. A stalled result channel freezes the whole pipeline.
module gaussian_split_kernel_matrix_unit #(
   parameter int MAX_POINTS = 64
) (
   input  logic           clock,
   input  logic           reset,
   // request channel
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [167:0]   req_tdata,  // rel_z, rel_px, rel_py, rel_pz, tot_px, tot_py, tot_pz
   input  logic [1:0]     req_tuser,  // op
   // result channel
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [39:0]    rsp_tdata,  // point_index, kernel_plus, kernel_minus
   output logic           rsp_tlast,
   // register writes
   input  logic           csr_we,
   input  logic [2:0]     csr_index,
   input  logic [23:0]    csr_wdata
);
   localparam int DIM = gsk_pkg::DIM;
   localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int RW  = DIM * gsk_pkg::COMP_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type                          state_ff, state_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [CW-1:0]                      scan_ff, scan_in;
   logic [gsk_pkg::WGT_W-1:0]          w_ff [DIM];
   logic [4:0]                         shift_ff;
   logic signed [gsk_pkg::XW-1:0]      x1_ff [DIM];
   logic signed [gsk_pkg::XW-1:0]      x2_ff [DIM];
   logic signed [gsk_pkg::XW-1:0]      cx [DIM];
   logic signed [gsk_pkg::XW-1:0]      sdz;
   gsk_pkg::meta_type                  rd_meta_ff, rd_meta_in;
   gsk_pkg::tok_type                   tok [DIM+1];
   logic [DIM-1:0]                     cell_busy;
   gsk_pkg::meta_type                  ex_meta;
   logic [gsk_pkg::KW-1:0]             ex_k1, ex_k2;
   logic                               ex_busy;
   logic                               rsp_valid_ff;
   logic [39:0]                        rsp_data_ff;
   logic                               rsp_last_ff;

   logic        en;
   logic        busy;
   logic        req_xfer;
   logic        is_query;
   logic        ram_we;
   logic        ram_re;
   logic [RW-1:0] ram_rdata;
   logic        scan_last;

   // pipeline advances unless a result is waiting
   assign en       = !rsp_valid_ff || rsp_tready;
   assign busy     = rd_meta_ff.valid | (|cell_busy) | ex_busy;
   assign req_tready = (state_ff == ST_IDLE) && !busy;
   assign req_xfer = req_tvalid && req_tready;
   assign is_query = req_xfer && (req_tuser == gsk_pkg::OP_QUERY) && (count_ff != '0);
   assign ram_we   = req_xfer && (req_tuser == gsk_pkg::OP_LOAD) &&
                     (count_ff < CW'(MAX_POINTS));
   assign ram_re   = en && (state_ff == ST_SCAN);
   assign scan_last = (CW'(scan_ff + 1'b1) == count_ff);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < DIM; l++) begin
            w_ff[l] <= gsk_pkg::WEIGHT_RST;
         end
         shift_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == gsk_pkg::REG_SHIFT) begin
            shift_ff <= csr_wdata[4:0];
         end else begin
            w_ff[csr_index] <= csr_wdata;
         end
      end
   end

   // request decode, store fill and scan sequencing
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      rd_meta_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser == gsk_pkg::OP_CLEAR) begin
                  count_in = '0;
               end else if (ram_we) begin
                  count_in = CW'(count_ff + 1'b1);
               end
               if (is_query) begin
                  state_in = ST_SCAN;
                  scan_in  = '0;
               end
            end
         end
         ST_SCAN: begin
            if (en) begin
               rd_meta_in.valid = 1'b1;
               rd_meta_in.idx   = gsk_pkg::IDXW'(scan_ff);
               rd_meta_in.last  = scan_last;
               scan_in          = CW'(scan_ff + 1'b1);
               if (scan_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         scan_ff  <= '0;
         rd_meta_ff.valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         scan_ff  <= scan_in;
         if (en) begin
            rd_meta_ff <= rd_meta_in;
         end
      end
   end

   // doubled sum and difference vectors of a query
   always_comb begin
      for (int l = 0; l < DIM; l++) begin
         cx[l] = gsk_pkg::XW'($signed(req_tdata[l*gsk_pkg::COMP_W +: gsk_pkg::COMP_W]));
      end
      sdz = gsk_pkg::XW'($signed(shift_ff) * cx[0]);
   end

   always_ff @(posedge clock) begin
      if (is_query) begin
         x1_ff[0] <= cx[0] <<< 1;
         x1_ff[1] <= cx[4] + cx[1];
         x1_ff[2] <= cx[5] + cx[2];
         x1_ff[3] <= cx[6] + cx[3] - sdz;
         x1_ff[4] <= cx[4] + cx[1];
         x1_ff[5] <= cx[5] + cx[2];
         x1_ff[6] <= cx[6] + cx[3] + sdz;
         x2_ff[0] <= cx[0] <<< 1;
         x2_ff[1] <= cx[4] - cx[1];
         x2_ff[2] <= cx[5] - cx[2];
         x2_ff[3] <= cx[6] - cx[3] - sdz;
         x2_ff[4] <= cx[4] - cx[1];
         x2_ff[5] <= cx[5] - cx[2];
         x2_ff[6] <= cx[6] - cx[3] + sdz;
      end
   end

   // point store, one row per point
   gsk_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(count_ff)),
      .wr_data (req_tdata),
      .rd_en   (ram_re),
      .rd_addr (AW'(scan_ff)),
      .rd_data (ram_rdata)
   );

   // row of cells, one per component
   assign tok[0].meta = rd_meta_ff;
   assign tok[0].row  = ram_rdata;
   assign tok[0].e1   = '0;
   assign tok[0].e2   = '0;

   for (genvar l = 0; l < DIM; l++) begin : g_cell
      gsk_cell #(
         .COMP (l)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .x1    (x1_ff[l]),
         .x2    (x2_ff[l]),
         .w     (w_ff[l]),
         .tok_i (tok[l]),
         .tok_o (tok[l+1]),
         .busy  (cell_busy[l])
      );
   end

   gsk_exp u_exp (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .meta_i (tok[DIM].meta),
      .e1     (tok[DIM].e1),
      .e2     (tok[DIM].e2),
      .meta_o (ex_meta),
      .k1     (ex_k1),
      .k2     (ex_k2),
      .busy   (ex_busy)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ex_meta.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {ex_k2, ex_k1, ex_meta.idx};
         rsp_last_ff <= ex_meta.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a scan never runs past the filled part of the store
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff < count_ff))
      else $error("scan index beyond point count");

   // the fill count never exceeds the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("point count beyond store depth");

   // kernel values never exceed one
   a_kernel_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[22:6] <= gsk_pkg::ONE_Q16 &&
                        rsp_data_ff[39:23] <= gsk_pkg::ONE_Q16))
      else $error("kernel value above one");

   // a finished scan returns to idle on the row that carries last
   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && en && scan_last) |=> (state_ff == ST_IDLE && rd_meta_ff.last))
      else $error("scan did not end on its last row");
endmodule

### src/gsk_ram.sv
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module gsk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [WIDTH-1:0]      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### src/gsk_cell.sv
// one cell of the row: adds the weighted squared term of one component to both sums
`timescale 1ns / 1ps
module gsk_cell #(
   parameter int COMP = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic signed [gsk_pkg::XW-1:0]      x1,
   input  logic signed [gsk_pkg::XW-1:0]      x2,
   input  logic [gsk_pkg::WGT_W-1:0]          w,
   input  gsk_pkg::tok_type                   tok_i,
   output gsk_pkg::tok_type                   tok_o,
   output logic                               busy
);
   typedef struct packed {
      gsk_pkg::tok_type           tok;
      logic [gsk_pkg::SQW-1:0]    sq1;
      logic [gsk_pkg::SQW-1:0]    sq2;
   } sq_type;

   typedef struct packed {
      gsk_pkg::tok_type  tok;
      logic [49:0]       a1;
      logic [55:0]       b1;
      logic [49:0]       a2;
      logic [55:0]       b2;
   } pp_type;

   typedef struct packed {
      gsk_pkg::tok_type         tok;
      logic [gsk_pkg::TW-1:0]   t1;
      logic [gsk_pkg::TW-1:0]   t2;
   } term_type;

   sq_type           sq_ff, sq_in;
   pp_type           pp_ff, pp_in;
   term_type         tm_ff, tm_in;
   gsk_pkg::tok_type ac_ff, ac_in;

   logic signed [gsk_pkg::DW-1:0] s2, d1, d2;
   logic [gsk_pkg::MW-1:0]        m1, m2;
   logic [47:0]                   hi1, hi2;
   logic [22:0]                   lo1, lo2;
   logic [48:0]                   term1, term2;
   logic [gsk_pkg::EW-1:0]        sum1, sum2;

   // doubled difference and its square
   always_comb begin
      s2 = gsk_pkg::DW'($signed(tok_i.row[COMP])) <<< 1;
      d1 = gsk_pkg::DW'(x1) - s2;
      d2 = gsk_pkg::DW'(x2) - s2;
      m1 = gsk_pkg::MW'(d1[gsk_pkg::DW-1] ? -d1 : d1);
      m2 = gsk_pkg::MW'(d2[gsk_pkg::DW-1] ? -d2 : d2);
      sq_in.tok = tok_i;
      sq_in.sq1 = gsk_pkg::SQW'(m1) * gsk_pkg::SQW'(m1);
      sq_in.sq2 = gsk_pkg::SQW'(m2) * gsk_pkg::SQW'(m2);
   end

   // weight times square, in high and low partial products
   always_comb begin
      pp_in.tok = sq_ff.tok;
      pp_in.a1  = 50'(sq_ff.sq1[57:32]) * 50'(w);
      pp_in.b1  = 56'(sq_ff.sq1[31:0]) * 56'(w);
      pp_in.a2  = 50'(sq_ff.sq2[57:32]) * 50'(w);
      pp_in.b2  = 56'(sq_ff.sq2[31:0]) * 56'(w);
   end

   // floor of w*d^2/4 in q.16, saturated at the flush level
   always_comb begin
      hi1   = 48'(pp_ff.a1 >> 2);
      hi2   = 48'(pp_ff.a2 >> 2);
      lo1   = 23'((57'({pp_ff.a1[1:0], 32'd0}) + 57'(pp_ff.b1)) >> 34);
      lo2   = 23'((57'({pp_ff.a2[1:0], 32'd0}) + 57'(pp_ff.b2)) >> 34);
      term1 = 49'(hi1) + 49'(lo1);
      term2 = 49'(hi2) + 49'(lo2);
      tm_in.tok = pp_ff.tok;
      tm_in.t1  = (term1 >= 49'(gsk_pkg::FLUSH_Q16)) ? gsk_pkg::TW'(gsk_pkg::FLUSH_Q16)
                                                      : term1[gsk_pkg::TW-1:0];
      tm_in.t2  = (term2 >= 49'(gsk_pkg::FLUSH_Q16)) ? gsk_pkg::TW'(gsk_pkg::FLUSH_Q16)
                                                      : term2[gsk_pkg::TW-1:0];
   end

   // saturating accumulate into the running sums
   always_comb begin
      sum1  = tm_ff.tok.e1 + gsk_pkg::EW'(tm_ff.t1);
      sum2  = tm_ff.tok.e2 + gsk_pkg::EW'(tm_ff.t2);
      ac_in = tm_ff.tok;
      ac_in.e1 = (sum1 >= gsk_pkg::FLUSH_Q16) ? gsk_pkg::FLUSH_Q16 : sum1;
      ac_in.e2 = (sum2 >= gsk_pkg::FLUSH_Q16) ? gsk_pkg::FLUSH_Q16 : sum2;
   end

   // stage registers, frozen while the result side stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff.tok.meta.valid <= 1'b0;
         pp_ff.tok.meta.valid <= 1'b0;
         tm_ff.tok.meta.valid <= 1'b0;
         ac_ff.meta.valid     <= 1'b0;
      end else if (en) begin
         sq_ff <= sq_in;
         pp_ff <= pp_in;
         tm_ff <= tm_in;
         ac_ff <= ac_in;
      end
   end

   assign tok_o = ac_ff;
   assign busy  = sq_ff.tok.meta.valid | pp_ff.tok.meta.valid |
                  tm_ff.tok.meta.valid | ac_ff.meta.valid;
endmodule

### src/gsk_exp.sv
// pipelined exp(-e) for the two sums: range reduction by ln2, fifth-order series, rounding shift
`timescale 1ns / 1ps
module gsk_exp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  gsk_pkg::meta_type             meta_i,
   input  logic [gsk_pkg::EW-1:0]        e1,
   input  logic [gsk_pkg::EW-1:0]        e2,
   output gsk_pkg::meta_type             meta_o,
   output logic [gsk_pkg::KW-1:0]        k1,
   output logic [gsk_pkg::KW-1:0]        k2,
   output logic                          busy
);
   localparam int STEPS = 5;

   typedef struct packed {
      logic                     flush;
      logic [gsk_pkg::EW-1:0]   e;
      logic [37:0]              prod;
   } ra_lane_type;

   typedef struct packed {
      gsk_pkg::meta_type     meta;
      ra_lane_type [1:0]     ln;
   } ra_type;

   typedef struct packed {
      logic                     flush;
      logic [4:0]               n;
      logic [15:0]              r;
      logic [gsk_pkg::KW-1:0]   t;
      logic [32:0]              p;
   } hl_lane_type;

   typedef struct packed {
      gsk_pkg::meta_type     meta;
      hl_lane_type [1:0]     ln;
   } hl_type;

   typedef struct packed {
      gsk_pkg::meta_type               meta;
      logic [1:0][gsk_pkg::KW-1:0]     k;
   } fo_type;

   ra_type  ra_ff, ra_in;
   hl_type  rb_ff, rb_in;
   hl_type  hp_ff [STEPS];
   hl_type  hp_in [STEPS];
   hl_type  hq_ff [STEPS];
   hl_type  hq_in [STEPS];
   fo_type  fo_ff, fo_in;

   logic [1:0][gsk_pkg::EW-1:0] e_in;
   logic [1:0][5:0]             nest;
   logic [1:0][21:0]            chk;
   logic [1:0][17:0]            rnd;
   logic [STEPS-1:0]            stage_busy;

   assign e_in[0] = e1;
   assign e_in[1] = e2;

   // estimate of e / ln2 by reciprocal multiply
   always_comb begin
      ra_in.meta = meta_i;
      for (int i = 0; i < 2; i++) begin
         ra_in.ln[i].flush = (e_in[i] >= gsk_pkg::FLUSH_Q16);
         ra_in.ln[i].e     = e_in[i];
         ra_in.ln[i].prod  = 38'(e_in[i]) * 38'(gsk_pkg::LN2_RECIP);
      end
   end

   // correct the estimate and form the remainder
   always_comb begin
      rb_in.meta = ra_ff.meta;
      for (int i = 0; i < 2; i++) begin
         nest[i] = ra_ff.ln[i].prod[37:32];
         chk[i]  = 22'(nest[i]) * 22'(gsk_pkg::LN2_Q16);
         rb_in.ln[i].flush = ra_ff.ln[i].flush;
         rb_in.ln[i].t     = gsk_pkg::ONE_Q16;
         rb_in.ln[i].p     = '0;
         if (chk[i] > 22'(ra_ff.ln[i].e)) begin
            rb_in.ln[i].n = 5'(nest[i] - 6'd1);
            rb_in.ln[i].r = 16'(22'(ra_ff.ln[i].e) - chk[i] + 22'(gsk_pkg::LN2_Q16));
         end else begin
            rb_in.ln[i].n = 5'(nest[i]);
            rb_in.ln[i].r = 16'(22'(ra_ff.ln[i].e) - chk[i]);
         end
      end
   end

   // horner steps t = 1 - r*t/k for k = 5 down to 1, two stages each
   for (genvar s = 0; s < STEPS; s++) begin : g_step
      always_comb begin
         hp_in[s] = (s == 0) ? rb_ff : hq_ff[(s == 0) ? 0 : s - 1];
         for (int i = 0; i < 2; i++) begin
            hp_in[s].ln[i].p = 33'(hp_in[s].ln[i].r) * 33'(hp_in[s].ln[i].t);
         end
      end

      always_comb begin
         hq_in[s] = hp_ff[s];
         for (int i = 0; i < 2; i++) begin
            hq_in[s].ln[i].t = gsk_pkg::ONE_Q16 -
                               gsk_pkg::quot_by(hp_ff[s].ln[i].p[32:16], STEPS - s);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            hp_ff[s].meta.valid <= 1'b0;
            hq_ff[s].meta.valid <= 1'b0;
         end else if (en) begin
            hp_ff[s] <= hp_in[s];
            hq_ff[s] <= hq_in[s];
         end
      end

      assign stage_busy[s] = hp_ff[s].meta.valid | hq_ff[s].meta.valid;
   end

   // scale by 2^-n with round half up, flush large sums to zero
   always_comb begin
      fo_in.meta = hq_ff[STEPS-1].meta;
      for (int i = 0; i < 2; i++) begin
         rnd[i] = 18'(hq_ff[STEPS-1].ln[i].t);
         if (hq_ff[STEPS-1].ln[i].flush) begin
            fo_in.k[i] = '0;
         end else if (hq_ff[STEPS-1].ln[i].n == 5'd0) begin
            fo_in.k[i] = hq_ff[STEPS-1].ln[i].t;
         end else begin
            rnd[i] = rnd[i] + (18'd1 << (hq_ff[STEPS-1].ln[i].n - 5'd1));
            fo_in.k[i] = gsk_pkg::KW'(rnd[i] >> hq_ff[STEPS-1].ln[i].n);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ra_ff.meta.valid <= 1'b0;
         rb_ff.meta.valid <= 1'b0;
         fo_ff.meta.valid <= 1'b0;
      end else if (en) begin
         ra_ff <= ra_in;
         rb_ff <= rb_in;
         fo_ff <= fo_in;
      end
   end

   assign meta_o = fo_ff.meta;
   assign k1     = fo_ff.k[0];
   assign k2     = fo_ff.k[1];
   assign busy   = ra_ff.meta.valid | rb_ff.meta.valid | fo_ff.meta.valid | (|stage_busy);
endmodule
